// File: hdl/drt_pkg.sv
// package for the divider and reloadable timer: constants, sequencer states, period decode
`timescale 1ns / 1ps

package drt_pkg;

  localparam int DIVIDER_PERIOD_DEF = 256;

  localparam int DIV_PHASE_W = 9;
  localparam int TMR_PHASE_W = 16;
  localparam int COUNT_W     = 8;
  // most increments one item can yield: 65535 / 16 fits in 12 bits
  localparam int INCR_W      = 12;
  localparam int SPAN_W      = 9;

  localparam logic [DIV_PHASE_W-1:0] DIV_PHASE_MAX = '1;
  localparam logic [TMR_PHASE_W-1:0] TMR_PHASE_MAX = '1;

  localparam logic [1:0] REG_RELOAD = 2'd0;
  localparam logic [1:0] REG_ENABLE = 2'd1;
  localparam logic [1:0] REG_SELECT = 2'd2;

  localparam logic [1:0] SEL_1024 = 2'd0;
  localparam logic [1:0] SEL_16   = 2'd1;
  localparam logic [1:0] SEL_64   = 2'd2;
  localparam logic [1:0] SEL_256  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_WRAP,
    ST_MOD,
    ST_FINISH
  } drt_state_t;

  // log2 of the timer period for each clock select code
  function automatic logic [3:0] period_shift(input logic [1:0] sel);
    logic [3:0] sh;
    unique case (sel)
      SEL_1024: sh = 4'd10;
      SEL_16:   sh = 4'd4;
      SEL_64:   sh = 4'd6;
      SEL_256:  sh = 4'd8;
      default:  sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

// File: hdl/divider_and_reload_timer.sv
// divider and reloadable timer with overflow interrupt, top level
//
//   channel | dir | handshake           | payload
//   s       | in  | s_tvalid / s_tready | s_tdata: cycles_elapsed
//   m       | out | m_tvalid / m_tready | m_tdata: divider_value, timer_value, timer_interrupt
//   cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// an item goes through accept, accumulate, wrap check and finish, and through a remainder
// step before finish when the timer count overflows: the remainder by the reload span is found
// by a shared restoring subtractor, one bit of the 12-bit increment count per cycle.
// rst is synchronous and clears the state, config, counters, phases, m_tvalid and irq.
// s_tready is high in idle even while a result waits on m; a stalled result holds the
// finishing step until the output register frees.
`timescale 1ns / 1ps

module divider_and_reload_timer #(
  parameter int DIVIDER_PERIOD = drt_pkg::DIVIDER_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] cycles_elapsed
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] divider_value, [15:8] timer_value,
                                 // [16] timer_interrupt, [23:17] zero
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import drt_pkg::*;

  localparam int CNT_W = $clog2(INCR_W);

  drt_state_t state, state_next;

  logic [COUNT_W-1:0]     reload_value;
  logic                   timer_enable;
  logic [1:0]             clock_select;

  logic [DIV_PHASE_W-1:0] div_phase;
  logic [COUNT_W-1:0]     div_count;
  logic [TMR_PHASE_W-1:0] tmr_phase;
  logic [COUNT_W-1:0]     tmr_count;

  logic [7:0]             cyc;
  logic [INCR_W-1:0]      incr;
  logic [SPAN_W-1:0]      rem;
  logic [SPAN_W-1:0]      span;
  logic [CNT_W-1:0]       step;
  logic                   irq;

  // accumulate step
  logic [DIV_PHASE_W:0]   div_sum;
  logic [DIV_PHASE_W-1:0] div_sat;
  logic [TMR_PHASE_W:0]   tmr_sum;
  logic [TMR_PHASE_W-1:0] tmr_sat;
  logic [3:0]             shift;

  // wrap step
  logic [SPAN_W-1:0]      to_wrap;

  // shared remainder unit
  logic [SPAN_W:0]        trial;
  logic                   fits;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    div_sum = {1'b0, div_phase} + (DIV_PHASE_W+1)'(cyc);
    div_sat = div_sum[DIV_PHASE_W] ? DIV_PHASE_MAX : div_sum[DIV_PHASE_W-1:0];
    tmr_sum = {1'b0, tmr_phase} + (TMR_PHASE_W+1)'(cyc);
    tmr_sat = tmr_sum[TMR_PHASE_W] ? TMR_PHASE_MAX : tmr_sum[TMR_PHASE_W-1:0];
    shift   = period_shift(clock_select);
    to_wrap = (SPAN_W)'(9'd256) - (SPAN_W)'(tmr_count);
    trial   = {rem, incr[INCR_W-1]};
    fits    = trial >= (SPAN_W+1)'(span);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (s_tvalid) state_next = ST_ACCUM;
      ST_ACCUM:  state_next = ST_WRAP;
      ST_WRAP: begin
        if (incr != '0 && (SPAN_W+1)'(incr) >= (SPAN_W+1)'(to_wrap) && incr[INCR_W-1:SPAN_W] == '0)
          state_next = ST_MOD;
        else if (incr[INCR_W-1:SPAN_W] != '0)
          state_next = ST_MOD;
        else
          state_next = ST_FINISH;
      end
      ST_MOD:    if (step == CNT_W'(INCR_W-1)) state_next = ST_FINISH;
      ST_FINISH: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload_value <= '0;
      timer_enable <= 1'b0;
      clock_select <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RELOAD: reload_value <= cfg_data;
        REG_ENABLE: timer_enable <= cfg_data[0];
        REG_SELECT: clock_select <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_phase <= '0;
      div_count <= '0;
      tmr_phase <= '0;
      tmr_count <= '0;
      m_tvalid  <= 1'b0;
      irq       <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) cyc <= s_tdata;
          irq <= 1'b0;
        end
        ST_ACCUM: begin
          if (div_sat >= DIV_PHASE_W'(DIVIDER_PERIOD)) begin
            div_phase <= div_sat - DIV_PHASE_W'(DIVIDER_PERIOD);
            div_count <= div_count + 1'b1;
          end else begin
            div_phase <= div_sat;
          end
          if (timer_enable) begin
            incr      <= INCR_W'(tmr_sat >> shift);
            tmr_phase <= tmr_sat & ~(TMR_PHASE_MAX << shift);
          end else begin
            incr      <= '0;
            tmr_phase <= tmr_sat;
          end
        end
        ST_WRAP: begin
          if (state_next == ST_MOD) begin
            // overflow: remainder of what is left by the reload span
            irq  <= 1'b1;
            incr <= incr - INCR_W'(to_wrap);
            span <= (SPAN_W)'(9'd256) - (SPAN_W)'(reload_value);
            rem  <= '0;
            step <= '0;
          end else begin
            tmr_count <= tmr_count + incr[COUNT_W-1:0];
          end
        end
        ST_MOD: begin
          rem  <= fits ? SPAN_W'(trial - (SPAN_W+1)'(span)) : trial[SPAN_W-1:0];
          incr <= {incr[INCR_W-2:0], 1'b0};
          step <= step + 1'b1;
          if (step == CNT_W'(INCR_W-1))
            tmr_count <= reload_value + (fits ? COUNT_W'(trial - (SPAN_W+1)'(span))
                                              : trial[COUNT_W-1:0]);
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, irq, tmr_count, div_count};
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_ACCUM))
    else $error("accepted transaction did not start accumulation");

  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MOD) |-> (rem < span))
    else $error("partial remainder not below reload span");

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && (!m_tvalid || m_tready)) |=> (m_tvalid && s_tready))
    else $error("finished result not presented");

  a_no_incr_skips_mod: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRAP && incr == '0) |=> (state == ST_FINISH && !irq))
    else $error("zero increments took the overflow path");
`endif

endmodule

// File: tb/drt_result_checker.sv
// result checker for the divider and reloadable timer: predicts each output transaction and compares it
`timescale 1ns / 1ps

module drt_result_checker #(
  parameter int DIVIDER_PERIOD = drt_pkg::DIVIDER_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending
);

  import drt_pkg::*;

  typedef struct packed {
    logic [COUNT_W-1:0] divider;
    logic [COUNT_W-1:0] timer;
    logic               irq;
  } timer_result_t;

  timer_result_t expected_counts[$];

  logic [COUNT_W-1:0]     reload_reg;
  logic                   enable_reg;
  logic [1:0]             select_reg;
  logic [DIV_PHASE_W-1:0] div_phase;
  logic [COUNT_W-1:0]     div_count;
  logic [TMR_PHASE_W-1:0] tmr_phase;
  logic [COUNT_W-1:0]     tmr_count;

  function automatic timer_result_t advance_counters(input logic [7:0] cycles);
    int unsigned   sum;
    int unsigned   per;
    int unsigned   incr;
    int unsigned   to_wrap;
    int unsigned   span;
    timer_result_t r;
    r.irq = 1'b0;

    // divider steps at most once per transaction
    sum = div_phase + cycles;
    if (sum > DIV_PHASE_MAX) sum = DIV_PHASE_MAX;
    if (sum >= DIVIDER_PERIOD) begin
      sum = sum - DIVIDER_PERIOD;
      div_count = div_count + 8'd1;
    end
    div_phase = sum[DIV_PHASE_W-1:0];

    // timer phase keeps gathering even while disabled
    sum = tmr_phase + cycles;
    if (sum > TMR_PHASE_MAX) sum = TMR_PHASE_MAX;
    if (enable_reg) begin
      case (select_reg)
        SEL_16:  per = 16;
        SEL_64:  per = 64;
        SEL_256: per = 256;
        default: per = 1024;
      endcase
      incr = sum / per;
      sum = sum % per;
      if (incr > 0) begin
        to_wrap = 256 - tmr_count;
        if (incr < to_wrap) begin
          tmr_count = tmr_count + incr[COUNT_W-1:0];
        end else begin
          span = 256 - reload_reg;
          incr = (incr - to_wrap) % span;
          r.irq = 1'b1;
          tmr_count = reload_reg + incr[COUNT_W-1:0];
        end
      end
    end
    tmr_phase = sum[TMR_PHASE_W-1:0];

    r.divider = div_count;
    r.timer = tmr_count;
    return r;
  endfunction

  always @(posedge clk) begin
    timer_result_t want;
    timer_result_t got;
    if (rst) begin
      reload_reg = '0;
      enable_reg = 1'b0;
      select_reg = SEL_1024;
      div_phase = '0;
      div_count = '0;
      tmr_phase = '0;
      tmr_count = '0;
      expected_counts.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RELOAD: reload_reg = cfg_data;
          REG_ENABLE: enable_reg = cfg_data[0];
          REG_SELECT: select_reg = cfg_data[1:0];
          default: ;
        endcase
      end
      // results come from older transactions, so retire before predicting the new one
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[7:0], m_tdata[15:8], m_tdata[16]};
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result, got divider %0d timer %0d irq %0b",
                   $time, got.divider, got.timer, got.irq);
          errors++;
        end else begin
          want = expected_counts.pop_front();
          if (got.divider !== want.divider) begin
            $display("%0t: divider_value expected %0d, got %0d", $time, want.divider,
                     got.divider);
            errors++;
          end
          if (got.timer !== want.timer) begin
            $display("%0t: timer_value expected %0d, got %0d", $time, want.timer, got.timer);
            errors++;
          end
          if (got.irq !== want.irq) begin
            $display("%0t: timer_interrupt expected %0b, got %0b", $time, want.irq, got.irq);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) expected_counts.push_back(advance_counters(s_tdata));
    end
    pending = expected_counts.size();
  end

endmodule

// File: tb/tb_divider_and_reload_timer.sv
// testbench top for the divider and reloadable timer: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_divider_and_reload_timer;

  import drt_pkg::*;

  localparam int         HOLD_CYCLES = 300;
  localparam int         RANDOM_BURST = 220;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int errors;
  int pending;
  int tx_idle_pct;
  int rx_stall_pct;
  int hold_req;
  int hold_done;

  divider_and_reload_timer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  drt_result_checker result_check (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .errors   (errors),
    .pending  (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = hold_req;
      end
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_cycles(input logic [7:0] cycles);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= cycles;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // unused upper data bits carry noise, the block keeps only the register width
  task automatic program_timer(input logic [7:0] reload, input logic en, input logic [1:0] sel);
    cfg_we <= 1'b1;
    cfg_index <= REG_RELOAD;
    cfg_data <= reload;
    @(negedge clk);
    cfg_index <= REG_ENABLE;
    cfg_data <= {7'($urandom), en};
    @(negedge clk);
    cfg_index <= REG_SELECT;
    cfg_data <= {6'($urandom), sel};
    @(negedge clk);
    if ($urandom_range(3) == 0) begin
      cfg_index <= REG_UNUSED;
      cfg_data <= 8'($urandom);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] reload;
    logic [7:0] cycles;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = REG_RELOAD;
    cfg_data = '0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    hold_req = 0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // timer disabled after reset, divider only
    send_cycles(8'd0);
    send_cycles(8'd255);
    send_cycles(8'd255);
    send_cycles(8'd1);
    settle();
    program_timer(8'd250, 1'b1, SEL_16);
    send_cycles(8'd255);
    send_cycles(8'd0);
    send_cycles(8'd16);
    send_cycles(8'd15);
    send_cycles(8'd255);
    // reload at the top leaves a span of one
    settle();
    program_timer(8'd255, 1'b1, SEL_1024);
    repeat (5) send_cycles(8'd255);
    settle();
    program_timer(8'd0, 1'b1, SEL_64);
    send_cycles(8'd255);
    send_cycles(8'd128);
    send_cycles(8'd64);
    settle();
    program_timer(8'd128, 1'b1, SEL_256);
    send_cycles(8'd255);
    send_cycles(8'd1);
    send_cycles(8'd127);

    // disabled timer gathers until the phase saturates
    settle();
    program_timer(8'($urandom), 1'b0, 2'($urandom));
    repeat (330) send_cycles(8'($urandom_range(200, 255)));

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 46; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 46; end
        default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
      endcase
      for (int k = 0; k < 2; k++) begin
        settle();
        case ($urandom_range(3))
          0: reload = 8'd0;
          1: reload = 8'd255;
          default: reload = 8'($urandom);
        endcase
        if (mode == 0 && k == 0) begin
          // drain the saturated phase at the fastest rate, with the output held off
          program_timer(reload, 1'b1, SEL_16);
          hold_req++;
        end else begin
          program_timer(reload, $urandom_range(9) != 0, 2'($urandom));
        end
        repeat (RANDOM_BURST) begin
          case ($urandom_range(9))
            0: cycles = 8'd0;
            1: cycles = 8'd255;
            default: cycles = 8'($urandom);
          endcase
          send_cycles(cycles);
        end
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/drt_pkg.sv
hdl/divider_and_reload_timer.sv
tb/drt_result_checker.sv
tb/tb_divider_and_reload_timer.sv
